// ===== design/assert_macros.svh =====
// Assertion macros shared by the supercapacitor supply switch modules.
// Each macro expands to a concurrent assertion, or to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssc: same-cycle check failed");
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssc: next-cycle check failed");
`else
`define SSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/ssc_pkg.sv =====
// Shared types and constants of the supercapacitor supply switch controller.
// No dependencies; used by the interfaces, the divider and the top level.
package ssc_pkg;

  localparam int CHASSIS_W = 18;
  localparam int TOTAL_W   = 18;
  localparam int SLOPE_W   = 19;
  localparam int ADC_W     = 12;
  localparam int ICH_W     = 12;
  localparam int CODE_W    = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 12;
  localparam int VTH_W      = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_ENTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_EXIT     = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1300;
  localparam logic [VTH_W-1:0]   ENTER_RESET = 15'd22000;
  localparam logic [VTH_W-1:0]   EXIT_RESET  = 15'd20100;

  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 16;
  localparam int STEP_W    = 6;

  localparam int HEAD_W = 28;
  localparam int PROD_W = HEAD_W + GAIN_W;
  localparam int MV_W   = 17;

  // ADC code times 325/34, as a multiplication by 325 * ceil(2^27 / 34).
  localparam int                    ADC_MULT_W   = 31;
  localparam int                    ADC_PROD_W   = ADC_W + ADC_MULT_W;
  localparam logic [ADC_MULT_W-1:0] ADC_MV_MULT  = 31'd1282963825;
  localparam int                    ADC_MV_SHIFT = 27;

  localparam logic [17:0]          RECIP_25    = 18'd167773;
  localparam int                   RECIP_SHIFT = 22;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [STEP_W-1:0]    steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/ssc_tick_if.sv =====
// Request channel carrying one control tick into the controller.
// Depends on ssc_pkg for the field widths.
interface ssc_tick_if;
  import ssc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CHASSIS_W-1:0]       chassis_power_mw;
  logic [TOTAL_W-1:0]         total_power_mw;
  logic signed [SLOPE_W-1:0]  power_slope_mw;
  logic [ADC_W-1:0]           cap_adc;
  logic [ICH_W-1:0]           charge_current_ma;

  modport source (output valid, chassis_power_mw, total_power_mw, power_slope_mw,
                  cap_adc, charge_current_ma, input ready);
  modport sink (input valid, chassis_power_mw, total_power_mw, power_slope_mw,
                cap_adc, charge_current_ma, output ready);
endinterface

// ===== design/ssc_result_if.sv =====
// Result channel carrying one controller decision per tick.
// Depends on ssc_pkg for the field widths.
interface ssc_result_if;
  import ssc_pkg::*;

  logic              valid;
  logic              ready;
  logic              dac_write;
  logic [CODE_W-1:0] dac_code;
  logic              on_capacitor;

  modport source (output valid, dac_write, dac_code, on_capacitor, input ready);
  modport sink (input valid, dac_write, dac_code, on_capacitor, output ready);
endinterface

// ===== design/ssc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ssc_pkg for the request and response structs, and on assert_macros.svh.
`include "assert_macros.svh"

module ssc_div (
  input  logic              clk,
  input  logic              rst,
  input  ssc_pkg::div_req_t req,
  output ssc_pkg::div_rsp_t rsp
);
  import ssc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

  `SSC_ASSERT_IMPL(a_no_restart, clk, rst, busy, !req.start)
  `SSC_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `SSC_ASSERT_IMPL(a_rem_below_den, clk, rst, busy || done, rem < den)

endmodule

// ===== design/supercap_supply_switch_ctrl.sv =====
// Supercapacitor supply switch controller: top level with sequencer and datapath.
// Depends on ssc_pkg, ssc_tick_if, ssc_result_if, ssc_div and assert_macros.svh.
//
// Each request on the tick channel is one control tick: chassis power, total
// power, power slope, the capacitor ADC code and the measured charge current.
// The block answers every tick with exactly one result: a DAC write strobe,
// the charge DAC code and the supply mode after the tick.
// Configuration is written by the user through cfg_we, cfg_index and cfg_data
// only while the block is idle, unenforced; register i of the list has index i.
// One tick occupies the block alone; the capacitor voltage comes from one
// reciprocal multiplication. Without a current the decision goes straight to
// the result; a direct current limit adds the code steps; a computed charge
// current adds two multiplies, the head sum and the divider, which resolves
// one of 36 quotient bits per cycle. Ready returns once the result is loaded.
// The result sits in an output register; the next tick is accepted while it
// waits, and a stalled receiver holds the result until it is taken, with the
// following tick parked in the sequencer until the register frees.
// A synchronous reset returns the mode to battery, loads the register
// defaults and drops any tick in progress.
`include "assert_macros.svh"

module supercap_supply_switch_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  ssc_tick_if.sink                         tick,
  ssc_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CAP_MV, S_DECIDE, S_MUL1, S_HEAD, S_MUL2,
    S_DIV_START, S_DIV_WAIT, S_CODE1, S_CODE2, S_DONE
  } state_t;

  state_t state;

  logic               auto_enable;
  logic [GAIN_W-1:0]  charge_gain_q8;
  logic [LIMIT_W-1:0] current_limit_ma;
  logic [VTH_W-1:0]   cap_enter_mv;
  logic [VTH_W-1:0]   cap_exit_mv;
  logic               supply_mode;

  logic [CHASSIS_W-1:0]      chassis;
  logic [TOTAL_W-1:0]        total;
  logic signed [SLOPE_W-1:0] slope;
  logic [ADC_W-1:0]          adc;
  logic [ICH_W-1:0]          ich;

  logic signed [MV_W-1:0] cap_mv;
  logic [HEAD_W-2:0]      base;
  logic [HEAD_W-1:0]      part;
  logic [HEAD_W-1:0]      head;
  logic [PROD_W-1:0]      prod;
  logic [LIMIT_W-1:0]     ma;
  logic [34:0]            recip;
  logic                   wr;
  logic [CODE_W-1:0]      code;
  logic                   mode_new;

  logic [ADC_PROD_W-1:0] cap_prod;
  logic [12:0]           code_raw;
  logic [12:0]           code_off;
  logic                  out_free;
  logic                  heavy;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ssc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable      <= 1'b0;
      charge_gain_q8   <= GAIN_RESET;
      current_limit_ma <= LIMIT_RESET;
      cap_enter_mv     <= ENTER_RESET;
      cap_exit_mv      <= EXIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AUTO_ENABLE: auto_enable      <= cfg_data[0];
        CFG_CHARGE_GAIN: charge_gain_q8   <= cfg_data[GAIN_W-1:0];
        CFG_CURRENT_LIM: current_limit_ma <= cfg_data[LIMIT_W-1:0];
        CFG_CAP_ENTER:   cap_enter_mv     <= cfg_data[VTH_W-1:0];
        CFG_CAP_EXIT:    cap_exit_mv      <= cfg_data[VTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cap_prod   = {{ADC_MULT_W{1'b0}}, adc} * {{ADC_W{1'b0}}, ADC_MV_MULT};
    code_raw   = recip[RECIP_SHIFT +: 13];
    code_off   = code_raw + 13'd60;
    out_free   = !result.valid || result.ready;
    heavy      = ((slope >= 19'sd1750) && (total >= 18'd40000)) || (total >= 18'd75000);
    div_req    = '0;
    case (state)
      S_DIV_START: begin
        div_req.start = 1'b1;
        div_req.num   = prod[PROD_W-1:8];
        div_req.den   = cap_mv[DIV_DEN_W-1:0];
        div_req.steps = STEP_W'(DIV_NUM_W);
      end
      default: ;
    endcase
  end

  assign tick.ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      supply_mode  <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            chassis <= tick.chassis_power_mw;
            total   <= tick.total_power_mw;
            slope   <= tick.power_slope_mw;
            adc     <= tick.cap_adc;
            ich     <= tick.charge_current_ma;
            state   <= S_CAP_MV;
          end
        end
        S_CAP_MV: begin
          cap_mv <= $signed({1'b0, cap_prod[ADC_MV_SHIFT +: MV_W-1]}) - 17'sd650;
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          wr       <= 1'b0;
          code     <= '0;
          mode_new <= supply_mode;
          state    <= S_DONE;
          if (auto_enable) begin
            if (!supply_mode) begin
              if (chassis <= 18'd80000) begin
                wr <= 1'b1;
                if (chassis < 18'd70000) begin
                  if (cap_mv > 17'sd5000) begin
                    state <= S_MUL1;
                  end else begin
                    ma    <= current_limit_ma;
                    state <= S_CODE1;
                  end
                end
              end else if (heavy) begin
                wr <= 1'b1;
                if (cap_mv > $signed({2'b00, cap_enter_mv})) begin
                  mode_new <= 1'b1;
                end
              end
            end else begin
              wr <= 1'b1;
              if ((cap_mv < $signed({2'b00, cap_exit_mv})) ||
                  ((slope <= 19'sd1500) && (total <= 18'd70000))) begin
                mode_new <= 1'b0;
              end
            end
          end
        end
        S_MUL1: begin
          base  <= 27'd75000000 - ({9'd0, chassis} * 27'd1000);
          part  <= {12'd0, cap_mv[DIV_DEN_W-1:0]} * {16'd0, ich};
          state <= S_HEAD;
        end
        S_HEAD: begin
          head  <= {1'b0, base} + part;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= {{GAIN_W{1'b0}}, head} * {{HEAD_W{1'b0}}, charge_gain_q8};
          state <= S_DIV_START;
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > {{(DIV_NUM_W-LIMIT_W){1'b0}}, current_limit_ma}) begin
              ma <= current_limit_ma;
            end else begin
              ma <= div_rsp.quo[LIMIT_W-1:0];
            end
            state <= S_CODE1;
          end
        end
        S_CODE1: begin
          recip <= {18'd0, ma, 5'd0} * {17'd0, RECIP_25};
          state <= S_CODE2;
        end
        S_CODE2: begin
          if (ma <= 12'd50) begin
            code <= '0;
          end else if (code_off > 13'd4095) begin
            code <= 12'd4095;
          end else begin
            code <= code_off[CODE_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            result.valid        <= 1'b1;
            result.dac_write    <= wr;
            result.dac_code     <= code;
            result.on_capacitor <= mode_new;
            supply_mode         <= mode_new;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SSC_ASSERT_IMPL(a_code_needs_write, clk, rst, result.valid,
                   result.dac_write || (result.dac_code == 12'd0))
  `SSC_ASSERT_NEXT(a_mode_holds, clk, rst, state != S_DONE, $stable(supply_mode))
  `SSC_ASSERT_IMPL(a_current_clamped, clk, rst, state == S_CODE1, ma <= current_limit_ma)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the supercapacitor supply switch controller.
// Drives control ticks over ssc_tick_if, predicts each decision in the bench and
// checks it against ssc_result_if; depends on ssc_pkg and both interfaces.
module testbench;
  import ssc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [CHASSIS_W-1:0] chassis;
    logic [TOTAL_W-1:0]   total;
    logic [SLOPE_W-1:0]   slope;
    logic [ADC_W-1:0]     adc;
    logic [ICH_W-1:0]     ich;
  } tick_t;

  typedef struct packed {
    logic              wr;
    logic [CODE_W-1:0] code;
    logic              on_cap;
  } decision_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssc_tick_if   tick_ch ();
  ssc_result_if result_ch ();

  supercap_supply_switch_ctrl u_top (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the configuration and of the supply mode.
  logic              auto_on;
  logic [GAIN_W-1:0]  gain;
  logic [LIMIT_W-1:0] limit_ma;
  logic [VTH_W-1:0]   enter_mv;
  logic [VTH_W-1:0]   exit_mv;
  logic              mode_cap;

  tick_t     queued_ticks[$];
  decision_t expected_decisions[$];
  tick_t     cur_tick;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;
  int unsigned results_taken;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned cycle_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [CODE_W-1:0] dac_code_for(input longint ma);
    longint c;
    if (ma <= 50) return '0;
    c = (ma * 32) / 25 + 60;
    if (c > 4095) c = 4095;
    return CODE_W'(c);
  endfunction

  function automatic decision_t decide_supply(input tick_t t);
    decision_t d;
    longint chassis, total, slope, mv, head, ma, lim;
    d = '0;
    chassis = longint'(t.chassis);
    total = longint'(t.total);
    slope = longint'($signed(t.slope));
    mv = (longint'(t.adc) * 325) / 34 - 650;
    lim = longint'(limit_ma);
    if (auto_on) begin
      if (!mode_cap) begin
        if (chassis <= 80000) begin
          d.wr = 1'b1;
          if (chassis < 70000) begin
            if (mv > 5000) begin
              head = 75000000 - chassis * 1000 + mv * longint'(t.ich);
              if (head <= 0) ma = 0;
              else ma = (head * longint'(gain)) / (256 * mv);
            end else begin
              ma = lim;
            end
            if (ma > lim) ma = lim;
            else if (ma <= 0) ma = 0;
            d.code = dac_code_for(ma);
          end
        end else if ((slope >= 1750 && total >= 40000) || total >= 75000) begin
          d.wr = 1'b1;
          if (mv > longint'(enter_mv)) mode_cap = 1'b1;
        end
      end else begin
        d.wr = 1'b1;
        if (mv < longint'(exit_mv) || (slope <= 1500 && total <= 70000)) mode_cap = 1'b0;
      end
    end
    d.on_cap = mode_cap;
    return d;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int s;
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 20) begin
      t.chassis = CHASSIS_W'($urandom());
      t.total = TOTAL_W'($urandom());
      t.slope = SLOPE_W'($urandom());
      t.adc = ADC_W'($urandom());
      t.ich = ICH_W'($urandom());
      return t;
    end
    case ($urandom_range(3, 0))
      0: t.chassis = CHASSIS_W'($urandom_range(69999, 0));
      1: t.chassis = CHASSIS_W'($urandom_range(82000, 68000));
      2: t.chassis = CHASSIS_W'($urandom_range(262143, 80001));
      default: t.chassis = CHASSIS_W'($urandom_range(120000, 80001));
    endcase
    if ($urandom_range(9, 0) == 0) t.total = TOTAL_W'($urandom());
    else t.total = TOTAL_W'($urandom_range(90000, 30000));
    if ($urandom_range(9, 0) == 0) begin
      t.slope = SLOPE_W'($urandom());
    end else begin
      s = int'($urandom_range(6000, 0)) - 2000;
      t.slope = SLOPE_W'(s);
    end
    sel = $urandom_range(9, 0);
    if (sel < 5) t.adc = ADC_W'($urandom_range(2500, 2000));
    else if (sel < 7) t.adc = ADC_W'($urandom_range(700, 0));
    else t.adc = ADC_W'($urandom());
    t.ich = ICH_W'($urandom());
    return t;
  endfunction

  task automatic add_tick(input int unsigned chassis, input int unsigned total, input int slope,
                          input int unsigned adc, input int unsigned ich);
    tick_t t;
    t.chassis = CHASSIS_W'(chassis);
    t.total = TOTAL_W'(total);
    t.slope = SLOPE_W'(slope);
    t.adc = ADC_W'(adc);
    t.ich = ICH_W'(ich);
    queued_ticks.push_back(t);
  endtask

  task automatic add_random_ticks(input int n);
    for (int i = 0; i < n; i++) queued_ticks.push_back(random_tick());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_ticks.size() != 0 || tick_ch.valid || expected_decisions.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      CFG_AUTO_ENABLE: auto_on = val[0];
      CFG_CHARGE_GAIN: gain = GAIN_W'(val);
      CFG_CURRENT_LIM: limit_ma = LIMIT_W'(val);
      CFG_CAP_ENTER:   enter_mv = VTH_W'(val);
      CFG_CAP_EXIT:    exit_mv = VTH_W'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int unsigned en, input int unsigned g, input int unsigned lim,
                            input int unsigned ent, input int unsigned ext);
    write_reg(CFG_AUTO_ENABLE, en);
    write_reg(CFG_CHARGE_GAIN, g);
    write_reg(CFG_CURRENT_LIM, lim);
    write_reg(CFG_CAP_ENTER, ent);
    write_reg(CFG_CAP_EXIT, ext);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Request driver: an offered request is held until accepted.
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) expected_decisions.push_back(decide_supply(cur_tick));
      if (!tick_ch.valid || tick_ch.ready) begin
        if (queued_ticks.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_tick = queued_ticks.pop_front();
          tick_ch.valid <= 1'b1;
          tick_ch.chassis_power_mw <= cur_tick.chassis;
          tick_ch.total_power_mw <= cur_tick.total;
          tick_ch.power_slope_mw <= cur_tick.slope;
          tick_ch.cap_adc <= cur_tick.adc;
          tick_ch.charge_current_ma <= cur_tick.ich;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      results_taken <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_taken <= results_taken + 1;
        if (expected_decisions.size() == 0) begin
          note_failure($sformatf("unexpected result: wr=%0d code=%0d on_cap=%0d",
                                 result_ch.dac_write, result_ch.dac_code,
                                 result_ch.on_capacitor));
        end else begin
          want = expected_decisions.pop_front();
          if (result_ch.dac_write !== want.wr || result_ch.dac_code !== want.code ||
              result_ch.on_capacitor !== want.on_cap)
            note_failure($sformatf(
              "mismatch: expected wr=%0d code=%0d on_cap=%0d, got wr=%0d code=%0d on_cap=%0d",
              want.wr, want.code, want.on_cap, result_ch.dac_write, result_ch.dac_code,
              result_ch.on_capacitor));
        end
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // One long receiver hold-off so that the block fills up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_taken >= 400) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned enter_pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.chassis_power_mw = '0;
    tick_ch.total_power_mw = '0;
    tick_ch.power_slope_mw = '0;
    tick_ch.cap_adc = '0;
    tick_ch.charge_current_ma = '0;
    result_ch.ready = 1'b0;
    auto_on = 1'b0;
    gain = GAIN_RESET;
    limit_ma = LIMIT_RESET;
    enter_mv = ENTER_RESET;
    exit_mv = EXIT_RESET;
    mode_cap = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 21;
    recv_idle_pct = 87;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Manual mode straight out of reset: nothing may change.
    add_random_ticks(30);
    wait_drained();

    write_reg(CFG_AUTO_ENABLE, 1);
    add_tick(0, 0, 0, 4095, 4095);
    add_tick(69999, 50000, 0, 2500, 0);
    add_tick(70000, 50000, 0, 2500, 100);
    add_tick(80000, 90000, 5000, 2500, 100);
    add_tick(30000, 50000, 0, 500, 1000);
    add_tick(80001, 39999, 1750, 2400, 100);
    add_tick(80001, 40000, 1749, 2400, 100);
    add_tick(80001, 40000, 1750, 2000, 100);
    add_tick(262143, 75000, -262144, 2400, 100);
    add_tick(0, 80000, 0, 4095, 0);
    add_tick(0, 70000, 1501, 4095, 0);
    add_tick(0, 70001, 1500, 4095, 0);
    add_tick(0, 70000, 1500, 4095, 0);
    add_tick(262143, 262143, 262143, 4095, 4095);
    add_tick(262143, 262143, 262143, 2170, 0);
    add_tick(100000, 75000, 0, 2300, 0);
    add_tick(0, 0, 0, 0, 0);
    add_tick(0, 0, 0, 4095, 0);
    wait_drained();
    write_reg(CFG_CHARGE_GAIN, 1);
    add_tick(0, 0, 0, 4095, 0);
    wait_drained();
    set_config(1, 65535, 4095, 0, 0);
    add_tick(0, 0, 0, 4095, 4095);
    wait_drained();
    write_reg(CFG_CURRENT_LIM, 0);
    add_tick(0, 0, 0, 300, 0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 21;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_config(1, 256, 1300, 22000, 20100);
        1: set_config(1, 65535, 4095, 0, 0);
        2: set_config(1, 0, 0, 32767, 32767);
        3: set_config(0, $urandom_range(65535, 0), $urandom_range(4095, 0),
                      $urandom_range(32767, 0), $urandom_range(32767, 0));
        4: set_config(1, 512, 2000, 25000, 15000);
        5: set_config(1, $urandom_range(65535, 0), $urandom_range(4095, 0),
                      $urandom_range(32767, 0), $urandom_range(32767, 0));
        6: set_config(1, 384, 4095, 21000, 21000);
        default: begin
          enter_pick = $urandom_range(30000, 15000);
          set_config(1, $urandom_range(1024, 0), $urandom_range(4095, 0), enter_pick,
                     $urandom_range(enter_pick, 10000));
        end
      endcase
      add_random_ticks(ph == 3 ? 80 : 270);
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_decisions.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
